// ----- rtl/core/screen_line_clipper_unit_assert.svh -----
// Assertion macros for the RTL of the line clipper.
`ifndef SCREEN_LINE_CLIPPER_UNIT_ASSERT_SVH
`define SCREEN_LINE_CLIPPER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SLC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("screen_line_clipper_unit: assertion failed");
`define SLC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("screen_line_clipper_unit: forbidden condition");
`else
`define SLC_ASSERT(name, clk, rst_n, prop)
`define SLC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/slc_pkg.sv -----
package slc_pkg;

  localparam int unsigned RegW    = 13;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutW    = 24;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam logic [RegW-1:0] WidthRst  = RegW'(640);
  localparam logic [RegW-1:0] HeightRst = RegW'(480);
  localparam logic [RegW-1:0] PixMax    = RegW'(4096);

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        line_color;
    logic [31:0]        draw_flags;
  } slc_in_t;

  typedef struct packed {
    logic [OutW-1:0] clip_start_x;
    logic [OutW-1:0] clip_start_y;
    logic [OutW-1:0] clip_end_x;
    logic [OutW-1:0] clip_end_y;
    logic [31:0]     out_color;
    logic [31:0]     out_flags;
  } slc_out_t;

  // Frame size in pixels: zero acts as one, oversize saturates.
  function automatic logic [RegW-1:0] frame_pixels(logic [RegW-1:0] r);
    logic [RegW-1:0] v;
    v = r;
    if (r == '0) begin
      v = RegW'(1);
    end else if (r > PixMax) begin
      v = PixMax;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/slc_move.sv -----
module slc_move #(
  parameter int unsigned FRAC_BITS      = 12,
  parameter int unsigned DEGENERATE_EPS = 4,
  parameter int unsigned AX             = 0,
  parameter int unsigned END            = 0,
  localparam int unsigned IW = 36 + FRAC_BITS,
  localparam int unsigned SW = 4 * IW + 64,
  localparam int unsigned LW = 13 + FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [SW-1:0] seg_i,
  input  logic [LW-1:0] lim_i,
  output logic          valid_o,
  output logic [SW-1:0] seg_o
);

  localparam int unsigned OB = 1 - AX;
  localparam int unsigned MW = IW - 1;
  localparam int unsigned H  = (MW + 1) / 2;
  localparam int unsigned HW = MW - H;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned QW = IW - 3;

  typedef struct packed {
    logic [1:0][1:0][IW-1:0] pt;
    logic [31:0]             color;
    logic [31:0]             flags;
  } seg_t;

  typedef struct packed {
    logic          need;
    logic          neg;
    logic [MW-1:0] dvs;
    seg_t          seg;
  } ctl_t;

  seg_t               si;
  logic signed [IW-1:0] p0a, p1a, pea, tgt, dlt, av, bv, lim_s, one_s;
  logic [IW-1:0]      abs_a, abs_b;
  logic               need, rej;
  ctl_t               c0_d;

  assign si    = seg_t'(seg_i);
  assign lim_s = $signed(IW'(lim_i));
  assign one_s = $signed(IW'(1) << FRAC_BITS);
  assign p0a   = $signed(si.pt[0][AX]);
  assign p1a   = $signed(si.pt[1][AX]);
  assign pea   = $signed(si.pt[END][AX]);
  assign tgt   = (END == 0) ? '0 : lim_s - one_s;
  assign need  = (END == 0) ? p0a[IW-1] : (p1a >= lim_s);
  assign dlt   = p1a - p0a;
  assign rej   = need && (dlt < $signed(IW'(DEGENERATE_EPS)));
  assign av    = tgt - pea;
  assign bv    = $signed(si.pt[1][OB]) - $signed(si.pt[0][OB]);
  assign abs_a = av[IW-1] ? IW'(-av) : IW'(av);
  assign abs_b = bv[IW-1] ? IW'(-bv) : IW'(bv);

  always_comb begin
    c0_d.need = need;
    c0_d.neg  = av[IW-1] ^ bv[IW-1];
    c0_d.dvs  = dlt[MW-1:0];
    c0_d.seg  = si;
  end

  // Stage 0: decide the move, take magnitudes
  logic          v0_q;
  ctl_t          c0_q;
  logic [MW-1:0] ma_q, mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i && !rej;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c0_q <= c0_d;
      ma_q <= need ? abs_a[MW-1:0] : '0;
      mb_q <= abs_b[MW-1:0];
    end
  end

  // Stage 1: partial products
  logic              v1_q;
  ctl_t              c1_q;
  logic [2*H-1:0]    ll_q;
  logic [H+HW-1:0]   lh_q, hl_q;
  logic [2*HW-1:0]   hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c1_q <= c0_q;
      ll_q <= ma_q[H-1:0] * mb_q[H-1:0];
      lh_q <= ma_q[H-1:0] * mb_q[MW-1:H];
      hl_q <= ma_q[MW-1:H] * mb_q[H-1:0];
      hh_q <= ma_q[MW-1:H] * mb_q[MW-1:H];
    end
  end

  // Stage 2 onward: product sum, then one quotient bit per stage
  logic [QW:0]   dv_q;
  ctl_t          dc_q   [QW+1];
  logic [PW-1:0] drem_q [QW+1];
  logic [QW-1:0] dquo_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dc_q[0]   <= c1_q;
      drem_q[0] <= PW'(ll_q) + (PW'(lh_q) << H) + (PW'(hl_q) << H) + (PW'(hh_q) << (2 * H));
      dquo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned Bit = QW - 1 - k;
    logic [PW:0]   trial;
    logic [PW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      trial = {1'b0, drem_q[k]} - ((PW+1)'(dc_q[k].dvs) << Bit);
      rem_d = drem_q[k];
      quo_d = dquo_q[k];
      if (!trial[PW]) begin
        rem_d      = trial[PW-1:0];
        quo_d[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dc_q[k+1]   <= dc_q[k];
        drem_q[k+1] <= rem_d;
        dquo_q[k+1] <= quo_d;
      end
    end
  end

  // Final stage: apply the signed offset and pin the axis to the edge
  ctl_t                 cf;
  seg_t                 sf_d;
  logic signed [IW-1:0] qs;
  logic                 vf_q;
  seg_t                 sf_q;

  assign cf = dc_q[QW];
  assign qs = cf.neg ? -$signed(IW'(dquo_q[QW])) : $signed(IW'(dquo_q[QW]));

  always_comb begin
    sf_d = cf.seg;
    if (cf.need) begin
      sf_d.pt[END][OB] = IW'($signed(cf.seg.pt[END][OB]) + qs);
      sf_d.pt[END][AX] = tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (adv_i) begin
      vf_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sf_q <= sf_d;
    end
  end

  assign valid_o = vf_q;
  assign seg_o   = SW'(sf_q);

endmodule

// ----- rtl/core/screen_line_clipper_unit.sv -----
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------
// input    | in_valid_i / in_stall_o | in_data_i   (slc_in_t, one segment)
// output   | out_valid_o/ out_stall_i| out_data_o  (slc_out_t, clipped)
// config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One segment enters per cycle while in_stall_o is low. The four restoring
// dividers, one quotient bit per stage, move the endpoints one after the
// other.
// Reset clears all valid bits and loads the frame size registers (640 x 480).
// The output register plus one skid entry let one more transfer in while a
// result waits; only a full skid entry stalls the input and freezes the pipe.
// Rejected segments simply drop their valid bit inside the pipe.
module screen_line_clipper_unit
  import slc_pkg::*;
#(
  parameter int unsigned FRAC_BITS      = 12,
  parameter int unsigned DEGENERATE_EPS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  slc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slc_out_t           out_data_o
);

  `include "screen_line_clipper_unit_assert.svh"

  // Internal coordinate width covers every intermediate value of both passes
  localparam int unsigned IW = 36 + FRAC_BITS;
  localparam int unsigned LW = RegW + FRAC_BITS;
  localparam int unsigned SW = 4 * IW + 64;

  typedef struct packed {
    logic [1:0][1:0][IW-1:0] pt;
    logic [31:0]             color;
    logic [31:0]             flags;
  } seg_t;

  // Frame size registers
  logic [RegW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameWidth:  width_q  <= cfg_data_i;
        CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clip limits in fixed point; the user must keep them stable whenever items are in flight (not enforced here)
  logic [1:0][LW-1:0] lim;
  assign lim[0] = LW'(frame_pixels(width_q)) << FRAC_BITS;
  assign lim[1] = LW'(frame_pixels(height_q)) << FRAC_BITS;

  // Advance the whole pipe unless the skid entry is occupied
  logic adv;
  logic skid_vld_q;
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Widen the incoming segment
  seg_t in_seg;
  always_comb begin
    in_seg.pt[0][0] = IW'(in_data_i.start_x);
    in_seg.pt[0][1] = IW'(in_data_i.start_y);
    in_seg.pt[1][0] = IW'(in_data_i.end_x);
    in_seg.pt[1][1] = IW'(in_data_i.end_y);
    in_seg.color    = in_data_i.line_color;
    in_seg.flags    = in_data_i.draw_flags;
  end

  logic [1:0] pass_vld;
  seg_t       pass_seg [2];

  // Pass 0 clips X against the width, pass 1 clips Y against the height
  for (genvar g = 0; g < 2; g++) begin : g_pass
    seg_t                 src, ord_d, ord_q;
    logic                 src_vld, ord_vld_q, rej, mv0_vld;
    logic signed [IW-1:0] p0a, p1a, lo, hi;
    logic [SW-1:0]        mv0_seg, mv1_seg;

    if (g == 0) begin : g_src_in
      assign src     = in_seg;
      assign src_vld = in_valid_i;
    end else begin : g_src_prev
      assign src     = pass_seg[0];
      assign src_vld = pass_vld[0];
    end

    assign p0a = $signed(src.pt[0][g]);
    assign p1a = $signed(src.pt[1][g]);
    assign lo  = (p0a > p1a) ? p1a : p0a;
    assign hi  = (p0a > p1a) ? p0a : p1a;
    // Drop segments wholly before zero or beyond the far edge
    assign rej = hi[IW-1] || (lo > $signed(IW'(lim[g])));

    always_comb begin
      ord_d = src;
      if (p0a > p1a) begin
        ord_d.pt[0] = src.pt[1];
        ord_d.pt[1] = src.pt[0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ord_vld_q <= 1'b0;
      end else if (adv) begin
        ord_vld_q <= src_vld && !rej;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ord_q <= ord_d;
      end
    end

    slc_move #(
      .FRAC_BITS      (FRAC_BITS),
      .DEGENERATE_EPS (DEGENERATE_EPS),
      .AX             (g),
      .END            (0)
    ) u_move_near (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (ord_vld_q),
      .seg_i   (SW'(ord_q)),
      .lim_i   (lim[g]),
      .valid_o (mv0_vld),
      .seg_o   (mv0_seg)
    );

    slc_move #(
      .FRAC_BITS      (FRAC_BITS),
      .DEGENERATE_EPS (DEGENERATE_EPS),
      .AX             (g),
      .END            (1)
    ) u_move_far (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (mv0_vld),
      .seg_i   (mv0_seg),
      .lim_i   (lim[g]),
      .valid_o (pass_vld[g]),
      .seg_o   (mv1_seg)
    );

    assign pass_seg[g] = seg_t'(mv1_seg);
  end

  // Clamp to [0, limit] and to the output range
  function automatic logic [OutW-1:0] clamp_out(logic [IW-1:0] v, logic [LW-1:0] l);
    logic [IW-1:0] u;
    logic [OutW-1:0] r;
    u = v;
    if (v[IW-1]) begin
      u = '0;
    end else if (v > IW'(l)) begin
      u = IW'(l);
    end
    r = u[OutW-1:0];
    if (u > IW'({OutW{1'b1}})) begin
      r = '1;
    end
    return r;
  endfunction

  slc_out_t fin_d, tail_q, out_q, skid_q;
  logic     tail_vld_q, out_vld_q;

  always_comb begin
    fin_d.clip_start_x = clamp_out(pass_seg[1].pt[0][0], lim[0]);
    fin_d.clip_start_y = clamp_out(pass_seg[1].pt[0][1], lim[1]);
    fin_d.clip_end_x   = clamp_out(pass_seg[1].pt[1][0], lim[0]);
    fin_d.clip_end_y   = clamp_out(pass_seg[1].pt[1][1], lim[1]);
    fin_d.out_color    = pass_seg[1].color;
    fin_d.out_flags    = pass_seg[1].flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q <= 1'b0;
    end else if (adv) begin
      tail_vld_q <= pass_vld[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tail_q <= fin_d;
    end
  end

  // Output register with one skid entry behind it
  logic out_free;
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      // Refill from the skid first, else from the pipe tail
      out_vld_q  <= skid_vld_q || tail_vld_q;
      skid_vld_q <= 1'b0;
    end else if (adv && tail_vld_q) begin
      // Output held: park the tail result
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : tail_q;
    end else if (adv && tail_vld_q) begin
      skid_q <= tail_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `SLC_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_vld_q |-> out_vld_q)
  `SLC_ASSERT(a_skid_holds, clk_i, rst_ni, (skid_vld_q && out_stall_i) |=> skid_vld_q)
  `SLC_ASSERT_NEVER(a_skid_fill_free, clk_i, rst_ni, $rose(skid_vld_q) && !$past(out_stall_i))

endmodule
